>>> rtl/bra_pkg.sv
// bitmap run allocator: shared types, state and action codes, constants
// no dependencies; imported by every module of the block

package bra_pkg;

    localparam int          DEF_MAX_BYTES = 512;
    localparam int          WORD_W        = 32;
    localparam int          RUN_W         = 13;
    localparam int          BIU_W         = 10;
    localparam logic [9:0]  BIU_RST       = 10'd512;
    localparam logic [7:0]  BYTE_ONES     = 8'hff;

    typedef enum logic [1:0] {
        ACT_TEST  = 2'd0,
        ACT_FIND  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN,
        ST_PLACE,
        ST_MISS
    } state_t;

    // what the word scanner reports for one map word
    typedef struct packed {
        logic             hit;
        logic [4:0]       pos;
        logic [RUN_W-1:0] carry;
    } scan_res_t;

endpackage

>>> rtl/bra_scan_unit.sv
// bitmap run allocator: word scanner, checks one 32-bit map word per use
// for the first point where the free run reaches the wanted length
// depends on bra_pkg

module bra_scan_unit
    import bra_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [RUN_W-1:0]  carry,
    input  logic [RUN_W-1:0]  want,
    output scan_res_t         res
);

    logic             has_lv [0:5][0:WORD_W-1];
    logic [4:0]       pos_lv [0:5][0:WORD_W-1];
    logic [WORD_W-1:0] hit;
    logic [RUN_W-1:0] need;
    logic [4:0]       run_in;

    // prefix scan: position of the highest used bit at or below each bit
    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            has_lv[0][j] = word[j];
            pos_lv[0][j] = 5'(j);
        end
        for (int l = 0; l < 5; l++)
        begin
            for (int j = 0; j < WORD_W; j++)
            begin
                has_lv[l+1][j] = has_lv[l][j];
                pos_lv[l+1][j] = pos_lv[l][j];
            end
            for (int j = (1 << l); j < WORD_W; j++)
            begin
                if (!has_lv[l][j])
                begin
                    has_lv[l+1][j] = has_lv[l][j - (1 << l)];
                    pos_lv[l+1][j] = pos_lv[l][j - (1 << l)];
                end
            end
        end
    end

    // carry is always below want, so need never wraps
    assign need = want - carry - RUN_W'(1);

    always_comb
    begin
        run_in = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            run_in = 5'(j) - pos_lv[5][j];
            if (has_lv[5][j])
                hit[j] = (want == {8'd0, run_in});
            else
                hit[j] = (need == RUN_W'(j));
        end
    end

    always_comb
    begin
        res.hit = |hit;
        res.pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit[j])
                res.pos = 5'(j);
        end
        if (has_lv[5][WORD_W-1])
            res.carry = RUN_W'(5'd31 - pos_lv[5][WORD_W-1]);
        else
            res.carry = carry + RUN_W'(WORD_W);
    end

endmodule

>>> rtl/bitmap_run_allocator_top.sv
// bitmap run allocator: top level with length register, sequencer and map memory
// depends on bra_pkg and bra_scan_unit
//
// Keeps an allocation bitmap of MAX_BYTES bytes (bit i in byte i/8, 1 used,
// 0 free) in a memory of 32-bit words, and runs one item at a time: test a
// bit, find the first run of run_length free bits inside the first
// bytes_in_use bytes, write a bit, or clear the whole map. An item is taken
// when start is high and busy is low; every item gives exactly one result,
// shown for one cycle with done high, and the receiver cannot stall it.
// Test and write read the map word first, then test the bit or write it back
// with the bit changed. Find reads and checks one map word per cycle in the
// word scanner, then on a hit registers the hit position and reports the run's
// start; a miss is reported after the last word in use. Clear-all writes one
// word per cycle over all (MAX_BYTES+3)/4 words; the same clearing pass runs
// after reset, with busy high and no result. The length register may be
// written at any time busy is low; cfg_ready is always high.

module bitmap_run_allocator_top
    import bra_pkg::*;
#(
    parameter int MAX_BYTES = DEF_MAX_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        action,
    input  logic [11:0]       bit_index,
    input  logic [RUN_W-1:0]  run_length,
    input  logic              bit_value,
    output logic              done,
    output logic              found,
    output logic [11:0]       start_index,
    output logic              bit_read,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BIU_W-1:0]  cfg_data
);

    localparam int MAP_WORDS = (MAX_BYTES + 3) / 4;
    localparam int MAP_BITS  = MAX_BYTES * 8;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // map memory
    logic [WORD_W-1:0] map_mem [0:MAP_WORDS-1];
    logic [WORD_W-1:0] rdata_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;

    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [1:0]        tail_reg, tail_next;
    logic [4:0]        bitpos_reg, bitpos_next;
    logic              val_reg, val_next;
    logic              inrange_reg, inrange_next;
    logic [RUN_W-1:0]  want_reg, want_next;
    logic [RUN_W-1:0]  carry_reg, carry_next;
    logic [4:0]        hitpos_reg, hitpos_next;
    logic              clr_reply_reg, clr_reply_next;
    logic [BIU_W-1:0]  biu_reg, biu_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [11:0]       start_reg, start_next;
    logic              bit_read_reg, bit_read_next;

    logic [BIU_W-1:0]  len_eff;
    logic [BIU_W-1:0]  len_m1;
    logic [WORD_W-1:0] scan_word;
    logic [RUN_W-1:0]  base;
    logic [RUN_W-1:0]  sum;
    scan_res_t         scan_res;

    bra_scan_unit u_scan (
        .word  (scan_word),
        .carry (carry_reg),
        .want  (want_reg),
        .res   (scan_res)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[wr_addr] <= wr_data;
        rdata_reg <= map_mem[rd_addr];
    end

    // length register, capped at the store size
    assign cfg_ready = 1'b1;
    assign biu_next  = (cfg_valid && cfg_ready) ? cfg_data : biu_reg;

    always_comb
    begin
        if (32'(biu_reg) > 32'(MAX_BYTES))
            len_eff = BIU_W'(MAX_BYTES);
        else
            len_eff = biu_reg;
        len_m1 = len_eff - BIU_W'(1);
    end

    // bytes past the searched length in the last word read as used
    always_comb
    begin
        scan_word = rdata_reg;
        if (addr_reg == last_reg)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (2'(b) > tail_reg)
                    scan_word[8*b +: 8] = BYTE_ONES;
            end
        end
    end

    assign base = RUN_W'({addr_reg, 5'b0});
    assign sum  = base + RUN_W'(hitpos_reg) + RUN_W'(1) - want_reg;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        tail_next      = tail_reg;
        bitpos_next    = bitpos_reg;
        val_next       = val_reg;
        inrange_next   = inrange_reg;
        want_next      = want_reg;
        carry_next     = carry_reg;
        hitpos_next    = hitpos_reg;
        clr_reply_next = clr_reply_reg;
        done_next      = 1'b0;
        found_next     = 1'b0;
        start_next     = '0;
        bit_read_next  = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = rdata_reg;
        rd_addr        = addr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg;
                wr_data = '0;
                if (addr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                    done_next  = clr_reply_reg;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (action_t'(action) == ACT_FIND)
                    rd_addr = '0;
                else
                    rd_addr = AW'(bit_index[11:5]);
                if (start)
                begin
                    act_next = action_t'(action);
                    case (action_t'(action))
                        ACT_TEST, ACT_WRITE:
                        begin
                            addr_next    = AW'(bit_index[11:5]);
                            bitpos_next  = bit_index[4:0];
                            val_next     = bit_value;
                            inrange_next = (32'(bit_index) < 32'(MAP_BITS));
                            state_next   = ST_ACCESS;
                        end
                        ACT_FIND:
                        begin
                            addr_next  = '0;
                            want_next  = run_length;
                            carry_next = '0;
                            last_next  = AW'(len_m1[BIU_W-1:2]);
                            tail_next  = len_m1[1:0];
                            if (run_length == '0 || len_eff == '0)
                                state_next = ST_MISS;
                            else
                                state_next = ST_SCAN;
                        end
                        ACT_CLEAR:
                        begin
                            addr_next      = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACCESS:
            begin
                if (act_reg == ACT_TEST)
                begin
                    bit_read_next = inrange_reg & rdata_reg[bitpos_reg];
                end
                else if (inrange_reg)
                begin
                    wr_en               = 1'b1;
                    wr_data             = rdata_reg;
                    wr_data[bitpos_reg] = val_reg;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // next word is fetched while this one is checked
                if (addr_reg == last_reg)
                    rd_addr = addr_reg;
                else
                    rd_addr = addr_reg + AW'(1);
                if (scan_res.hit)
                begin
                    hitpos_next = scan_res.pos;
                    state_next  = ST_PLACE;
                end
                else if (addr_reg == last_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next  = addr_reg + AW'(1);
                    carry_next = scan_res.carry;
                end
            end
            ST_PLACE:
            begin
                done_next  = 1'b1;
                found_next = 1'b1;
                start_next = sum[11:0];
                state_next = ST_IDLE;
            end
            ST_MISS:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            clr_reply_reg <= 1'b0;
            biu_reg       <= BIU_RST;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            start_reg     <= '0;
            bit_read_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            clr_reply_reg <= clr_reply_next;
            biu_reg       <= biu_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            start_reg     <= start_next;
            bit_read_reg  <= bit_read_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        last_reg    <= last_next;
        tail_reg    <= tail_next;
        bitpos_reg  <= bitpos_next;
        val_reg     <= val_next;
        inrange_reg <= inrange_next;
        want_reg    <= want_next;
        carry_reg   <= carry_next;
        hitpos_reg  <= hitpos_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign start_index = start_reg;
    assign bit_read    = bit_read_reg;

endmodule

>>> rtl/bra_checker.sv
// bitmap run allocator: port-level checker and its bind to the top level
// depends on bra_pkg and bitmap_run_allocator_top

module bra_checker
    import bra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        action,
    input  logic [11:0]       bit_index,
    input  logic [RUN_W-1:0]  run_length,
    input  logic              bit_value,
    input  logic              done,
    input  logic              found,
    input  logic [11:0]       start_index,
    input  logic              bit_read,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [BIU_W-1:0]  cfg_data
);

    // an accepted item always raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an item was taken");

    // a result comes out with the block ready for the next item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // each result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // result fields are quiet outside the strobe, and a find never reports a bit
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!done |-> (!found && start_index == '0 && !bit_read)) and
        (done |-> !(found && bit_read)))
        else $error("result fields inconsistent with strobe");

endmodule

bind bitmap_run_allocator_top bra_checker u_bra_checker (.*);
